@@ rtl/vector_mean_normalizer_macros.svh @@
// ----------------------------------------------------------------------------
// vector_mean_normalizer assertion macros
// concurrent checks clocked on the rising edge, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef VECTOR_MEAN_NORMALIZER_MACROS_SVH
`define VECTOR_MEAN_NORMALIZER_MACROS_SVH

// same-cycle implication
`define VMN_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define VMN_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ rtl/vmn_pkg.sv @@
// ----------------------------------------------------------------------------
// vmn_pkg
// shared types and constants of the mean normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vmn_pkg;

	// quotient bits produced by the divider, integer bit included
	localparam int Q_STEPS = 16;

	// Q1.15 result constants
	localparam logic [15:0] Q_ONE   = 16'h8000;
	localparam logic [15:0] OUT_MAX = 16'h7fff;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/vmn_sample_buf.sv @@
// ----------------------------------------------------------------------------
// vmn_sample_buf
// sample store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmn_sample_buf #(
	parameter int DEPTH = 64,
	parameter int W     = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]             rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/vmn_divider.sv @@
// ----------------------------------------------------------------------------
// vmn_divider
// restoring shift-subtract divider, one quotient bit per cycle
// num must not exceed den; quot = floor(num * 2^15 / den), at most 2^15
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmn_divider #(
	parameter int W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [W-1:0]             num,
	input  logic [W-1:0]             den,
	output logic [15:0]              quot,
	output vmn_pkg::div_stat_t       stat
);

	import vmn_pkg::*;

	localparam int STEP_BITS = $clog2(Q_STEPS);

	logic [W:0]           rem_q;
	logic [W:0]           rem_sub;
	logic                 ge;
	logic [Q_STEPS-1:0]   quot_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;

	// one compare and subtract per step
	assign ge      = rem_q >= {1'b0, den};
	assign rem_sub = ge ? (rem_q - {1'b0, den}) : rem_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_BITS'(1);
			if (step_q == STEP_BITS'(Q_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
		end else if (busy_q) begin
			rem_q  <= {rem_sub[W-1:0], 1'b0};
			quot_q <= {quot_q[Q_STEPS-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/vector_mean_normalizer.sv @@
// ----------------------------------------------------------------------------
// vector_mean_normalizer
// buffers a vector of signed samples, then emits each as
// (n*x - sum) / (n*(max-min)) in saturated Q1.15
// ----------------------------------------------------------------------------
//  channel | dir | tdata               | tlast    | tuser
//  s_      | in  | sample              | last_in  | -
//  m_      | out | norm_value (Q1.15)  | last_out | flat_range, overflowed
//
//  loading takes one sample per cycle while s_tready is high
//  after the last sample: one setup step, then per result the steps fetch,
//  multiply, sign, 16 divider steps and output load
//  s_tready stays low from the last sample until the final result is loaded
//  a stalled output holds the divider at its result, nothing is lost
//  reset clears the sequencer and running statistics; the sample store is not
//  cleared, only entries written in the current vector are read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_mean_normalizer #(
	parameter int MAX_LEN     = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
	input  logic                                  s_tlast,  // last_in
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [15:0]                           m_tdata,  // norm_value
	output logic                                  m_tlast,  // last_out
	output logic [1:0]                            m_tuser   // flat_range, overflowed
);

	import vmn_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int NB = $clog2(MAX_LEN + 1);
	localparam int AB = $clog2(MAX_LEN);
	localparam int SUMW = SB + NB;
	localparam int DW = NB + SB;
	localparam int PW = DW + 2;
	localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB - 1){1'b0}}};
	localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB - 1){1'b1}}};

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_RANGE = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_SIGN  = 6'b010000,
		ST_DIV   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [NB-1:0]          cnt_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [SB-1:0]   max_q;
	logic signed [SB-1:0]   min_q;
	logic                   drop_q;
	logic [NB-1:0]          idx_q;
	logic                   out_valid_q;
	logic [15:0]            out_data_q;
	logic                   out_last_q;
	logic                   out_flat_q;
	logic                   out_drop_q;
	logic [DW-1:0]          den_q;
	logic                   flat_q;
	logic signed [PW-1:0]   diff_q;
	logic                   neg_q;

	logic signed [SB-1:0]   x;
	logic                   in_xfer;
	logic                   has_room;
	logic signed [SB:0]     range;
	logic signed [SB:0]     mul_b;
	logic signed [NB:0]     cnt_s;
	logic signed [PW-1:0]   mul_p;
	logic [PW-1:0]          diff_abs;
	logic [SB-1:0]          rd_data;
	logic [15:0]            quot;
	div_stat_t              div_stat;
	logic                   div_start;
	logic                   div_ok;
	logic                   out_free;
	logic                   out_load;
	logic                   last_elem;
	logic [15:0]            result;

	assign x        = $signed(s_tdata[SB-1:0]);
	assign s_tready = (state_q == ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign has_room = cnt_q < NB'(MAX_LEN);

	// shared multiplier: n*range during setup, n*x per element
	assign range = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
	assign mul_b = (state_q == ST_RANGE) ? range : {rd_data[SB-1], rd_data};
	assign cnt_s = {1'b0, cnt_q};
	assign mul_p = cnt_s * mul_b;

	assign diff_abs  = diff_q[PW-1] ? PW'(-diff_q) : PW'(diff_q);
	assign div_start = (state_q == ST_SIGN);
	assign div_ok    = div_stat.done && !div_stat.busy;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == ST_DIV) && div_ok && out_free;
	assign last_elem = (idx_q + NB'(1)) == cnt_q;

	// flat-range zero, sign, truncation and saturation of the quotient
	always_comb begin
		if (flat_q) begin
			result = '0;
		end else if (neg_q) begin
			result = ~quot + 16'd1;
		end else if (quot == Q_ONE) begin
			result = OUT_MAX;
		end else begin
			result = quot;
		end
	end

	vmn_sample_buf #(
		.DEPTH (MAX_LEN),
		.W     (SB)
	) u_buf (
		.clk     (clk),
		.wr_en   (in_xfer && has_room),
		.wr_addr (cnt_q[AB-1:0]),
		.wr_data (x),
		.rd_en   (state_q == ST_FETCH),
		.rd_addr (idx_q[AB-1:0]),
		.rd_data (rd_data)
	);

	vmn_divider #(
		.W (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff_abs[DW-1:0]),
		.den    (den_q),
		.quot   (quot),
		.stat   (div_stat)
	);

	// sequencer and running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			sum_q       <= '0;
			max_q       <= SMP_MIN;
			min_q       <= SMP_MAX;
			drop_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: a new load replaces a same-cycle transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (s_tvalid) begin
						if (has_room) begin
							cnt_q <= cnt_q + NB'(1);
							sum_q <= sum_q + SUMW'(x);
							if (x > max_q) begin
								max_q <= x;
							end
							if (x < min_q) begin
								min_q <= x;
							end
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_RANGE;
						end
					end
				end
				ST_RANGE: begin
					idx_q   <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SIGN;
				end
				ST_SIGN: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (out_load) begin
						idx_q <= idx_q + NB'(1);
						if (last_elem) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							max_q   <= SMP_MIN;
							min_q   <= SMP_MAX;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_RANGE) begin
			den_q  <= mul_p[DW-1:0];
			flat_q <= (range == '0);
		end
		if (state_q == ST_MUL) begin
			diff_q <= mul_p - PW'(sum_q);
		end
		if (state_q == ST_SIGN) begin
			neg_q <= diff_q[PW-1];
		end
		if (out_load) begin
			out_data_q <= result;
			out_last_q <= last_elem;
			out_flat_q <= flat_q;
			out_drop_q <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_drop_q, out_flat_q};

endmodule

@@ rtl/vmn_checker.sv @@
// ----------------------------------------------------------------------------
// vmn_checker
// port-level checks of the mean normalizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vector_mean_normalizer_macros.svh"

module vmn_checker #(
	parameter int IN_W = 16
) (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [IN_W-1:0] s_tdata,  // sample
	input logic            s_tlast,  // last_in
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [15:0]     m_tdata,  // norm_value
	input logic            m_tlast,  // last_out
	input logic [1:0]      m_tuser   // flat_range, overflowed
);

	logic in_last_xfer;

	assign in_last_xfer = s_tvalid && s_tready && s_tlast;

	// stalled result holds
	`VMN_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
		"stalled result changed")

	// flat range forces a zero value
	`VMN_ASSERT_NOW(a_flat_zero, clk, arst_n, m_tvalid && m_tuser[0],
		m_tdata == 16'h0000, "flat range with nonzero value")

	// input closes after the final sample of a vector
	`VMN_ASSERT_NEXT(a_in_close, clk, arst_n, in_last_xfer,
		!s_tready, "input still open after last sample")

	// while the input is open only a final result can be pending
	`VMN_ASSERT_NOW(a_open_last, clk, arst_n, s_tready && m_tvalid,
		m_tlast, "non-final result while input open")

	// stalled sample holds
	`VMN_ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready,
		s_tvalid && $stable(s_tdata) && $stable(s_tlast),
		"stalled sample changed")

endmodule

bind vector_mean_normalizer vmn_checker #(
	.IN_W (((SAMPLE_BITS + 7) / 8) * 8)
) u_vmn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for vector_mean_normalizer
// streams vectors of signed samples into the block, keeps its own copy of the
// running sum, maximum, minimum and sample store, works out each normalized
// Q1.15 element and compares it, field by field, with every output transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int VEC_DEPTH     = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int PHASE_ITEMS   = 60;

	// one input element and one normalized element
	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} sample_item_t;

	typedef struct packed {
		logic [15:0] norm;
		logic        last;
		logic        flat;
		logic        ovf;
	} norm_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // sample
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // norm_value
	logic        m_tlast;
	logic [1:0]  m_tuser;        // flat_range, overflowed

	sample_item_t pending_samples[$];
	norm_result_t norm_expected[$];
	sample_item_t drive_item;
	norm_result_t got_result;
	norm_result_t want_result;

	int items_queued = 0;
	int items_accepted = 0;
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_granted = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// running statistics of the vector being loaded
	logic signed [15:0] vec_store [VEC_DEPTH];
	longint             vec_sum;
	logic signed [15:0] vec_max;
	logic signed [15:0] vec_min;
	int                 vec_count;
	logic               vec_dropped;

	vector_mean_normalizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_statistics();
		vec_sum     = 0;
		vec_max     = -16'sd32768;
		vec_min     = 16'sd32767;
		vec_count   = 0;
		vec_dropped = 1'b0;
	endfunction

	// accumulate one sample; on the last one queue every normalized element
	function automatic void accumulate_and_normalize(input logic signed [15:0] x,
			input logic last);
		longint       num;
		longint       den;
		longint       q;
		logic         flat;
		norm_result_t r;
		if (vec_count < VEC_DEPTH) begin
			vec_store[vec_count] = x;
			vec_count++;
			vec_sum += x;
			if (x > vec_max)
				vec_max = x;
			if (x < vec_min)
				vec_min = x;
		end else begin
			vec_dropped = 1'b1;
		end
		if (last) begin
			flat = (vec_count == 0) || (vec_max == vec_min);
			for (int i = 0; i < vec_count; i++) begin
				q = 0;
				if (!flat) begin
					num = (longint'(vec_count) * longint'(vec_store[i]) - vec_sum) * 32768;
					den = longint'(vec_count) * (longint'(vec_max) - longint'(vec_min));
					q = num / den;
					if (q > 32767)
						q = 32767;
					if (q < -32768)
						q = -32768;
				end
				r.norm = q[15:0];
				r.last = (i + 1 == vec_count);
				r.flat = flat;
				r.ovf  = vec_dropped;
				norm_expected = {norm_expected, r};
			end
			clear_statistics();
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// sender: offers the next pending element, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			clear_statistics();
		end else begin
			if (s_tvalid && s_tready) begin
				accumulate_and_normalize(s_tdata, s_tlast);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_item = pending_samples.pop_front();
					s_tvalid   <= 1'b1;
					s_tdata    <= drive_item.sample;
					s_tlast    <= drive_item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_granted != hold_requests) begin
			hold_granted <= hold_granted + 1;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each output transfer with the oldest expected element
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = '{norm: m_tdata, last: m_tlast, flat: m_tuser[0], ovf: m_tuser[1]};
			if (norm_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got_result);
				error_count++;
			end else begin
				want_result = norm_expected.pop_front();
				check_field("norm_value", want_result.norm, got_result.norm);
				check_field("last_out", want_result.last, got_result.last);
				check_field("flat_range", want_result.flat, got_result.flat);
				check_field("overflowed", want_result.ovf, got_result.ovf);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic push_sample(input logic [15:0] value, input logic last);
		sample_item_t entry;
		entry = '{sample: value, last: last};
		pending_samples = {pending_samples, entry};
		items_queued++;
	endtask

	// element content by vector flavor: wide, narrow, flat, extremes
	function automatic logic [15:0] pick_element(input int flavor, input logic [15:0] base);
		logic [15:0] v;
		case (flavor)
			0: v = 16'($urandom_range(65535));
			1: v = base + 16'($urandom_range(15));
			2: v = base;
			default: begin
				case ($urandom_range(4))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					3: v = 16'hffff;
					default: v = 16'($urandom_range(65535));
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic push_vector(input int len);
		int          flavor;
		logic [15:0] base;
		flavor = $urandom_range(3);
		base   = 16'($urandom_range(65535));
		for (int i = 0; i < len; i++)
			push_sample(pick_element(flavor, base), i == len - 1);
	endtask

	task automatic push_random_vectors(input int count);
		int start;
		start = items_queued;
		while (items_queued - start < count) begin
			if ($urandom_range(24) == 0)
				push_vector($urandom_range(72, 60));
			else
				push_vector($urandom_range(12, 1));
		end
	endtask

	task automatic wait_all_done();
		do
			@(negedge clk);
		while (items_accepted != items_queued || norm_expected.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed vectors: single element, extremes, flat ranges, mixed signs
		push_sample(16'd7, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7fff, 1'b1);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h0000, 1'b1);
		push_sample(16'd100, 1'b0);
		push_sample(16'd100, 1'b0);
		push_sample(16'd100, 1'b1);
		push_sample(-16'sd5, 1'b0);
		push_sample(16'd3, 1'b0);
		push_sample(16'd3, 1'b0);
		push_sample(16'd3, 1'b1);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h7fff, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8001, 1'b1);
		wait_all_done();

		// no idling; long receiver hold-off while a full buffer and a
		// vector whose dropped sample carries the last flag stream in
		hold_requests = hold_requests + 1;
		push_vector(64);
		push_vector(65);
		push_random_vectors(PHASE_ITEMS / 2);
		wait_all_done();

		// sender mostly idle
		send_idle_pct = 88;
		push_random_vectors(PHASE_ITEMS);
		wait_all_done();

		// receiver mostly stalled
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		push_random_vectors(PHASE_ITEMS);
		wait_all_done();

		// both sides idling now and then
		send_idle_pct  = 21;
		recv_stall_pct = 21;
		push_random_vectors(PHASE_ITEMS);
		wait_all_done();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vmn_pkg.sv
rtl/vmn_sample_buf.sv
rtl/vmn_divider.sv
rtl/vector_mean_normalizer.sv
rtl/vmn_checker.sv
tb/testbench.sv
